[sv/mdec_pkg.sv]
package mdec_pkg;

	// register file size
	localparam int REG_COUNT_DEF = 32;

	// opcodes
	localparam logic [5:0] OP_RTYPE = 6'h00;
	localparam logic [5:0] OP_J     = 6'h02;
	localparam logic [5:0] OP_BEQ   = 6'h04;
	localparam logic [5:0] OP_BNE   = 6'h05;
	localparam logic [5:0] OP_ADDI  = 6'h08;
	localparam logic [5:0] OP_LW    = 6'h23;
	localparam logic [5:0] OP_SW    = 6'h2B;

	// r-type function codes
	localparam logic [5:0] FN_JR  = 6'h08;
	localparam logic [5:0] FN_ADD = 6'h20;
	localparam logic [5:0] FN_SUB = 6'h22;
	localparam logic [5:0] FN_AND = 6'h24;
	localparam logic [5:0] FN_OR  = 6'h25;
	localparam logic [5:0] FN_XOR = 6'h26;
	localparam logic [5:0] FN_NOR = 6'h27;

	// control flag bits
	localparam logic [9:0] FLG_NONE     = 10'h000;
	localparam logic [9:0] FLG_REGDST   = 10'h001;
	localparam logic [9:0] FLG_REGWRITE = 10'h002;
	localparam logic [9:0] FLG_ALUSRC   = 10'h004;
	localparam logic [9:0] FLG_MEMREAD  = 10'h008;
	localparam logic [9:0] FLG_MEMTOREG = 10'h010;
	localparam logic [9:0] FLG_MEMWRITE = 10'h020;
	localparam logic [9:0] FLG_BEQ      = 10'h040;
	localparam logic [9:0] FLG_BNE      = 10'h080;
	localparam logic [9:0] FLG_JUMP     = 10'h100;
	localparam logic [9:0] FLG_JUMPREG  = 10'h200;

	typedef enum logic [2:0] {
		ALU_NOP   = 3'd0,
		ALU_ADD   = 3'd1,
		ALU_SUB   = 3'd2,
		ALU_AND   = 3'd3,
		ALU_OR    = 3'd4,
		ALU_XOR   = 3'd5,
		ALU_NOR   = 3'd6,
		ALU_PASSA = 3'd7
	} alu_op_t;

	typedef enum logic [1:0] {
		ST_BUBBLE = 2'd0,
		ST_VALID  = 2'd1,
		ST_ERROR  = 2'd2
	} status_t;

	typedef struct packed {
		status_t    status;
		alu_op_t    alu;
		logic [9:0] flags;
	} ctrl_t;

	typedef struct packed {
		logic [31:0]        instruction;
		logic [31:0]        pc;
		logic [31:0]        pc_plus_4;
		logic               fetch_valid;
		logic               stall_req;
		logic               flush;
		logic               wb_enable;
		logic [4:0]         wb_register;
		logic signed [31:0] wb_data;
	} in_word_t;

	typedef struct packed {
		status_t            status;
		logic [31:0]        out_pc;
		logic [31:0]        out_pc_plus_4;
		logic [4:0]         src_reg;
		logic [4:0]         tgt_reg;
		logic [4:0]         dst_reg;
		logic signed [15:0] immediate;
		logic [31:0]        jump_target;
		logic signed [31:0] src_value;
		logic signed [31:0] tgt_value;
		alu_op_t            alu_operation;
		logic [9:0]         control_flags;
	} out_word_t;

endpackage

[sv/mdec_if.sv]
interface mdec_in_if;
	import mdec_pkg::*;

	logic     valid;
	logic     ready;
	in_word_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface mdec_out_if;
	import mdec_pkg::*;

	logic      valid;
	logic      ready;
	out_word_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[sv/mdec_ram.sv]
module mdec_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/mdec_rf.sv]
module mdec_rf #(
	parameter int REG_COUNT = mdec_pkg::REG_COUNT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [$clog2(REG_COUNT)-1:0] rs_addr,
	input  logic [$clog2(REG_COUNT)-1:0] rt_addr,
	input  logic                         wr_en,
	input  logic [$clog2(REG_COUNT)-1:0] wr_addr,
	input  logic [31:0]                  wr_data,
	output logic [31:0]                  rs_data,
	output logic [31:0]                  rt_data
);
	import mdec_pkg::*;

	logic [REG_COUNT-1:0] written_q;
	logic [31:0]          rs_ram;
	logic [31:0]          rt_ram;
	logic                 rs_fwd_q;
	logic                 rt_fwd_q;
	logic                 rs_vld_q;
	logic                 rt_vld_q;
	logic [31:0]          fwd_data_q;

	// two copies so that rs and rt are read in the same cycle
	mdec_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_ram_rs (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rs_addr),
		.rdata (rs_ram)
	);

	mdec_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_ram_rt (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rt_addr),
		.rdata (rt_ram)
	);

	// per-entry written marks, an unwritten entry reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (wr_en) begin
			written_q[wr_addr] <= 1'b1;
		end
	end

	// same-word write is forwarded past the ram read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rs_fwd_q <= 1'b0;
			rt_fwd_q <= 1'b0;
			rs_vld_q <= 1'b0;
			rt_vld_q <= 1'b0;
		end else if (rd_en) begin
			rs_fwd_q <= wr_en && (wr_addr == rs_addr);
			rt_fwd_q <= wr_en && (wr_addr == rt_addr);
			rs_vld_q <= written_q[rs_addr];
			rt_vld_q <= written_q[rt_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			fwd_data_q <= wr_data;
		end
	end

	assign rs_data = rs_fwd_q ? fwd_data_q : (rs_vld_q ? rs_ram : '0);
	assign rt_data = rt_fwd_q ? fwd_data_q : (rt_vld_q ? rt_ram : '0);

endmodule

[sv/mdec_ctrl.sv]
module mdec_ctrl (
	input  logic [31:0]         instruction,
	input  logic                fetch_valid,
	input  logic                stall_req,
	input  logic                flush,
	output mdec_pkg::ctrl_t     ctrl
);
	import mdec_pkg::*;

	logic [5:0] opcode;
	logic [5:0] funct;

	assign opcode = instruction[31:26];
	assign funct  = instruction[5:0];

	// control unit
	always_comb begin
		ctrl.status = ST_VALID;
		ctrl.alu    = ALU_NOP;
		ctrl.flags  = FLG_NONE;
		if (flush || stall_req || !fetch_valid) begin
			ctrl.status = ST_BUBBLE;
		end else begin
			case (opcode)
				OP_RTYPE: begin
					ctrl.flags = FLG_REGDST | FLG_REGWRITE;
					case (funct)
						FN_ADD: ctrl.alu = ALU_ADD;
						FN_SUB: ctrl.alu = ALU_SUB;
						FN_AND: ctrl.alu = ALU_AND;
						FN_OR:  ctrl.alu = ALU_OR;
						FN_XOR: ctrl.alu = ALU_XOR;
						FN_NOR: ctrl.alu = ALU_NOR;
						FN_JR: begin
							ctrl.alu   = ALU_PASSA;
							ctrl.flags = FLG_JUMPREG;
						end
						default: begin
							ctrl.status = ST_ERROR;
							ctrl.flags  = FLG_NONE;
						end
					endcase
				end
				OP_ADDI: begin
					ctrl.alu   = ALU_ADD;
					ctrl.flags = FLG_ALUSRC | FLG_REGWRITE;
				end
				OP_LW: begin
					ctrl.alu   = ALU_ADD;
					ctrl.flags = FLG_ALUSRC | FLG_REGWRITE | FLG_MEMREAD | FLG_MEMTOREG;
				end
				OP_SW: begin
					ctrl.alu   = ALU_ADD;
					ctrl.flags = FLG_ALUSRC | FLG_MEMWRITE;
				end
				OP_BEQ: begin
					ctrl.alu   = ALU_SUB;
					ctrl.flags = FLG_BEQ;
				end
				OP_BNE: begin
					ctrl.alu   = ALU_SUB;
					ctrl.flags = FLG_BNE;
				end
				OP_J: begin
					ctrl.flags = FLG_JUMP;
				end
				default: begin
					ctrl.status = ST_ERROR;
				end
			endcase
		end
	end

endmodule

[sv/mips_decode_stage_top.sv]
// channel    modport   word         role
// instr_ch   sink      in_word_t    if/id word with write-back request
// decode_ch  source    out_word_t   id/ex word, one per accepted input word
//
// one word per cycle sustained while decode_ch is ready; after acceptance a result passes
// the ram read stage, then the output register
// the write-back of a word is applied in its accept cycle and forwarded to its own read
// arst_n clears pipeline valids and the register-file written marks (all read zero)
// a stalled output register back-pressures the read stage, which holds its ram data
module mips_decode_stage_top #(
	parameter int REG_COUNT = mdec_pkg::REG_COUNT_DEF
) (
	input logic        clk,
	input logic        arst_n,
	mdec_in_if.sink    instr_ch,
	mdec_out_if.source decode_ch
);
	import mdec_pkg::*;

	localparam int AW = $clog2(REG_COUNT);

	logic        accept;
	logic        s1_free;
	logic        s2_free;
	logic        move_s2;
	logic        vld_s1;
	logic        vld_s2;
	logic        wr_en;
	ctrl_t       ctrl_in;
	ctrl_t       ctrl_s1;
	logic [31:0] instr_s1;
	logic [31:0] pc_s1;
	logic [31:0] pc4_s1;
	logic [31:0] rs_data;
	logic [31:0] rt_data;
	out_word_t   res_word;
	out_word_t   res_s2;

	// handshake
	assign s2_free        = !vld_s2 || decode_ch.ready;
	assign s1_free        = !vld_s1 || s2_free;
	assign move_s2        = vld_s1 && s2_free;
	assign instr_ch.ready = s1_free;
	assign accept         = instr_ch.valid && s1_free;

	// write-back, register 0 ignored
	assign wr_en = accept && instr_ch.data.wb_enable && (instr_ch.data.wb_register != '0);

	mdec_rf #(.REG_COUNT(REG_COUNT)) u_rf (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rs_addr (instr_ch.data.instruction[21 +: AW]),
		.rt_addr (instr_ch.data.instruction[16 +: AW]),
		.wr_en   (wr_en),
		.wr_addr (instr_ch.data.wb_register[AW-1:0]),
		.wr_data (instr_ch.data.wb_data),
		.rs_data (rs_data),
		.rt_data (rt_data)
	);

	mdec_ctrl u_ctrl (
		.instruction (instr_ch.data.instruction),
		.fetch_valid (instr_ch.data.fetch_valid),
		.stall_req   (instr_ch.data.stall_req),
		.flush       (instr_ch.data.flush),
		.ctrl        (ctrl_in)
	);

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (accept) begin
				vld_s1 <= 1'b1;
			end else if (move_s2) begin
				vld_s1 <= 1'b0;
			end
			if (move_s2) begin
				vld_s2 <= 1'b1;
			end else if (decode_ch.ready) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	// read stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			ctrl_s1  <= ctrl_in;
			instr_s1 <= instr_ch.data.instruction;
			pc_s1    <= instr_ch.data.pc;
			pc4_s1   <= instr_ch.data.pc_plus_4;
		end
	end

	// result word, all zero except status unless decoded
	always_comb begin
		res_word        = '0;
		res_word.status = ctrl_s1.status;
		if (ctrl_s1.status == ST_VALID) begin
			res_word.out_pc        = pc_s1;
			res_word.out_pc_plus_4 = pc4_s1;
			res_word.src_reg       = instr_s1[25:21];
			res_word.tgt_reg       = instr_s1[20:16];
			res_word.dst_reg       = instr_s1[15:11];
			res_word.immediate     = instr_s1[15:0];
			res_word.jump_target   = {pc4_s1[31:28], instr_s1[25:0], 2'b00};
			res_word.src_value     = rs_data;
			res_word.tgt_value     = rt_data;
			res_word.alu_operation = ctrl_s1.alu;
			res_word.control_flags = ctrl_s1.flags;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (move_s2) begin
			res_s2 <= res_word;
		end
	end

	assign decode_ch.valid = vld_s2;
	assign decode_ch.data  = res_s2;

endmodule
